// ----- src/chtm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chtm_pkg
// Shared types and codes for the cell hit time merger.
// ----------------------------------------------------------------------------
package chtm_pkg;

  localparam int COUNT_W = 7;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

  localparam logic [1:0] REG_MERGE_WINDOW = 2'd0;
  localparam logic [1:0] REG_HIT_LIMIT    = 2'd1;
  localparam logic [1:0] REG_ENERGY_THR   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CNT_RD,
    S_CNT_LATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_ADD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MERGE_WR,
    S_TAIL,
    S_EMIT_DROP,
    S_RO_RD,
    S_RO_CHK,
    S_RO_END
  } chtm_state_t;

  typedef struct packed {
    logic load_item;
    logic rd_count;
    logic load_n;
    logic rd_store;
    logic inc_i;
    logic mul;
    logic add;
    logic div_start;
    logic wr_merge;
    logic wr_append;
    logic wr_count_clear;
    logic sweep;
    logic emit_drop;
    logic emit_empty;
    logic emit_pend_last;
    logic pend_push;
  } chtm_cmd_t;

  typedef struct packed {
    logic op;
    logic valid_cell;
    logic zero_energy;
    logic n_zero;
    logic i_last;
    logic match;
    logic qualify;
    logic pend_v;
    logic room;
    logic out_free;
    logic div_busy;
    logic sweep_done;
  } chtm_stat_t;

endpackage
`default_nettype wire

// ----- src/chtm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chtm_div
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module chtm_div #(
  parameter int NW = 58,
  parameter int DW = 33,
  parameter int QW = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [DW-1:0] den,
  output logic                      busy,
  output logic signed      [QW-1:0] quot
);
  localparam int RW = NW + DW + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem;
  logic [RW-1:0]   dd;
  logic [QW-1:0]   q;
  logic            neg;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   mag;

  assign mag  = num[NW-1] ? NW'(-num) : NW'(num);
  assign quot = neg ? QW'(-q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NW-1];
      rem <= RW'(mag);
      dd  <= RW'(den) << (QW - 1);
      q   <= '0;
    end else if (busy) begin
      if (rem >= dd) begin
        rem <= rem - dd;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q   <= {q[QW-2:0], 1'b0};
      end
      dd <= dd >> 1;
    end
  end

endmodule
`default_nettype wire

// ----- src/chtm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chtm_datapath
// Hit memories, scan index, weighted-average arithmetic and result register.
// ----------------------------------------------------------------------------
module chtm_datapath #(
  parameter int NUM_CELLS     = 2048,
  parameter int HITS_PER_CELL = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire chtm_pkg::chtm_cmd_t cmd,
  output chtm_pkg::chtm_stat_t     stat,
  input  wire logic                opcode,
  input  wire logic [10:0]         cell_req,
  input  wire logic [23:0]         deposit_time,
  input  wire logic [23:0]         deposit_energy,
  input  wire logic [15:0]         local_z,
  input  wire logic [15:0]         merge_window,
  input  wire logic [6:0]          hit_limit,
  input  wire logic [23:0]         energy_threshold,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [10:0]              hit_cell,
  output logic [23:0]              hit_time,
  output logic [31:0]              hit_energy,
  output logic [15:0]              hit_z,
  output logic                     last
);
  import chtm_pkg::*;

  localparam int CW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int DEPTH = NUM_CELLS * HITS_PER_CELL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] LAST_CELL = CW'(NUM_CELLS - 1);
  localparam logic [COUNT_W-1:0] HPC  = COUNT_W'(HITS_PER_CELL);

  logic [COUNT_W-1:0] count_mem [NUM_CELLS];
  logic [23:0]        time_mem  [DEPTH];
  logic [31:0]        energy_mem[DEPTH];
  logic [15:0]        z_mem     [DEPTH];

  // item
  logic               op;
  logic [10:0]        cell_id;
  logic signed [23:0] t;
  logic [23:0]        d;
  logic signed [15:0] z;

  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] i;
  logic [COUNT_W-1:0] lim;
  logic [CW-1:0]      sweep_idx;
  logic [CW-1:0]      cidx;
  logic [AW-1:0]      base;
  logic [AW-1:0]      addr;

  logic signed [23:0] rd_t;
  logic [31:0]        rd_e;
  logic signed [15:0] rd_z;

  logic signed [56:0] p_te;
  logic signed [48:0] p_td;
  logic signed [48:0] p_ze;
  logic signed [40:0] p_zd;
  logic signed [57:0] num_t;
  logic signed [49:0] num_z;
  logic [32:0]        den;

  logic               busy_t;
  logic               busy_z;
  logic signed [23:0] q_t;
  logic signed [15:0] q_z;

  logic               pend_v;
  logic signed [23:0] pend_t;
  logic [31:0]        pend_e;
  logic signed [15:0] pend_z;

  logic signed [24:0] diff;
  logic [24:0]        adiff;
  logic               out_free;

  assign cidx = CW'(cell_id);
  assign base = AW'(cidx) * AW'(HITS_PER_CELL);
  assign addr = base + AW'(i);
  assign lim  = (hit_limit < HPC) ? hit_limit : HPC;

  assign diff  = 25'(rd_t) - 25'(t);
  assign adiff = diff[24] ? 25'(-diff) : 25'(diff);

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.op          = op;
    stat.valid_cell  = 32'(cell_id) < NUM_CELLS;
    stat.zero_energy = (d == '0);
    stat.n_zero      = (n == '0);
    stat.i_last      = (i + 1'b1 == n);
    stat.match       = adiff < 25'(merge_window);
    stat.qualify     = rd_e >= 32'(energy_threshold);
    stat.pend_v      = pend_v;
    stat.room        = n < lim;
    stat.out_free    = out_free;
    stat.div_busy    = busy_t || busy_z;
    stat.sweep_done  = (sweep_idx == LAST_CELL);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op      <= opcode;
      cell_id <= cell_req;
      t       <= deposit_time;
      d       <= deposit_energy;
      z       <= local_z;
    end
  end

  // count memory: clearing sweep, append and readout writes
  always_ff @(posedge clk) begin
    if (cmd.sweep) count_mem[sweep_idx] <= '0;
    else if (cmd.wr_append) count_mem[cidx] <= n + 1'b1;
    else if (cmd.wr_count_clear) count_mem[cidx] <= '0;
    if (cmd.rd_count) count_q <= count_mem[cidx];
  end

  always_ff @(posedge clk) begin
    if (rst) sweep_idx <= '0;
    else if (cmd.sweep) sweep_idx <= sweep_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n <= (count_q > HPC) ? HPC : count_q;
      i <= '0;
    end else if (cmd.inc_i) begin
      i <= i + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_merge) begin
      time_mem[addr]   <= q_t;
      z_mem[addr]      <= q_z;
      energy_mem[addr] <= den[32] ? '1 : den[31:0];
    end else if (cmd.wr_append) begin
      time_mem[base + AW'(n)]   <= t;
      z_mem[base + AW'(n)]      <= z;
      energy_mem[base + AW'(n)] <= 32'(d);
    end
    if (cmd.rd_store) begin
      rd_t <= time_mem[addr];
      rd_e <= energy_mem[addr];
      rd_z <= z_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_te <= rd_t * $signed({1'b0, rd_e});
      p_td <= t * $signed({1'b0, d});
      p_ze <= rd_z * $signed({1'b0, rd_e});
      p_zd <= z * $signed({1'b0, d});
    end
    if (cmd.add) begin
      num_t <= 58'(p_te) + 58'(p_td);
      num_z <= 50'(p_ze) + 50'(p_zd);
      den   <= 33'(rd_e) + 33'(d);
    end
  end

  chtm_div #(.NW(58), .DW(33), .QW(24)) u_div_t (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num_t), .den(den),
    .busy(busy_t), .quot(q_t)
  );

  chtm_div #(.NW(50), .DW(33), .QW(16)) u_div_z (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(num_z), .den(den),
    .busy(busy_z), .quot(q_z)
  );

  always_ff @(posedge clk) begin
    if (rst) pend_v <= 1'b0;
    else if (cmd.load_n) pend_v <= 1'b0;
    else if (cmd.pend_push) pend_v <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_push) begin
      pend_t <= rd_t;
      pend_e <= rd_e;
      pend_z <= rd_z;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_drop || cmd.emit_empty || cmd.emit_pend_last ||
             (cmd.pend_push && pend_v)) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_drop) begin
      status <= ST_DROP; hit_cell <= cell_id; hit_time <= t;
      hit_energy <= 32'(d); hit_z <= z; last <= 1'b1;
    end else if (cmd.emit_empty) begin
      status <= ST_EMPTY; hit_cell <= cell_id; hit_time <= '0;
      hit_energy <= '0; hit_z <= '0; last <= 1'b1;
    end else if (cmd.emit_pend_last || (cmd.pend_push && pend_v)) begin
      status <= ST_HIT; hit_cell <= cell_id; hit_time <= pend_t;
      hit_energy <= pend_e; hit_z <= pend_z; last <= cmd.emit_pend_last;
    end
  end

endmodule
`default_nettype wire

// ----- src/chtm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// chtm_ctrl
// Sequencer for clearing, deposit scan/merge/append and readout.
// ----------------------------------------------------------------------------
module chtm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire chtm_pkg::chtm_stat_t stat,
  output chtm_pkg::chtm_cmd_t       cmd
);
  import chtm_pkg::*;

  chtm_state_t state;
  chtm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        cmd.rd_count = 1'b1;
        state_next   = S_CNT_LATCH;
      end
      S_CNT_LATCH: begin
        cmd.load_n = 1'b1;
        if (stat.op == OP_DEPOSIT) begin
          if (!stat.valid_cell || stat.zero_energy) state_next = S_IDLE;
          else state_next = S_SCAN_RD;
        end else begin
          state_next = stat.valid_cell ? S_RO_RD : S_RO_END;
        end
      end
      S_SCAN_RD: begin
        if (stat.n_zero) state_next = S_TAIL;
        else begin
          cmd.rd_store = 1'b1;
          state_next   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.match) state_next = S_MUL;
        else if (stat.i_last) state_next = S_TAIL;
        else begin
          cmd.inc_i  = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) state_next = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        cmd.wr_merge = 1'b1;
        state_next   = S_IDLE;
      end
      S_TAIL: begin
        if (stat.room) begin
          cmd.wr_append = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_EMIT_DROP;
        end
      end
      S_EMIT_DROP: begin
        if (stat.out_free) begin
          cmd.emit_drop = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RO_RD: begin
        if (stat.n_zero) state_next = S_RO_END;
        else begin
          cmd.rd_store = 1'b1;
          state_next   = S_RO_CHK;
        end
      end
      S_RO_CHK: begin
        if (!(stat.qualify && stat.pend_v && !stat.out_free)) begin
          cmd.pend_push = stat.qualify;
          if (stat.i_last) state_next = S_RO_END;
          else begin
            cmd.inc_i  = 1'b1;
            state_next = S_RO_RD;
          end
        end
      end
      S_RO_END: begin
        if (stat.out_free) begin
          cmd.emit_pend_last = stat.pend_v;
          cmd.emit_empty     = !stat.pend_v;
          cmd.wr_count_clear = stat.valid_cell;
          state_next         = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/cell_hit_time_merger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cell_hit_time_merger
// Per-cell hit lists with time-window merging and thresholded readout.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | opcode, cell_req, deposit_time,
//           |                      | deposit_energy, local_z
//  out      | out_valid / out_stall| status, hit_cell, hit_time, hit_energy,
//           |                      | hit_z, last
//  config   | APB psel / penable   | paddr, pwdata, prdata, pready
//
// After reset a clearing pass zeroes the hit count of every cell, one cell a
// cycle; no request is taken until it ends. One request is handled at a time:
// a deposit reads the cell's hit count, then scans each stored hit in turn;
// an ignored deposit (invalid cell or zero energy) ends after the count read.
// A hit within the merge window is merged through multiply, add and the
// dividers in place of the final append; a cell at its limit emits a drop.
// A readout scans each stored hit in turn, waiting while the result register
// is held by out_stall. A held result never blocks new requests unless a new
// result must be written.
// ----------------------------------------------------------------------------
module cell_hit_time_merger #(
  parameter int NUM_CELLS     = 2048,
  parameter int HITS_PER_CELL = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [10:0] cell_req,
  input  wire logic [23:0] deposit_time,
  input  wire logic [23:0] deposit_energy,
  input  wire logic [15:0] local_z,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [10:0]      hit_cell,
  output logic [23:0]      hit_time,
  output logic [31:0]      hit_energy,
  output logic [15:0]      hit_z,
  output logic             last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import chtm_pkg::*;

  logic [15:0] merge_window;
  logic [6:0]  hit_limit;
  logic [23:0] energy_threshold;

  chtm_cmd_t  cmd;
  chtm_stat_t stat;

  assign pready = 1'b1;

  // register writes complete on the access cycle; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_window     <= 16'd500;
      hit_limit        <= 7'd16;
      energy_threshold <= 24'd1000;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MERGE_WINDOW: merge_window     <= pwdata[15:0];
        REG_HIT_LIMIT:    hit_limit        <= pwdata[6:0];
        REG_ENERGY_THR:   energy_threshold <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MERGE_WINDOW: prdata = 32'(merge_window);
      REG_HIT_LIMIT:    prdata = 32'(hit_limit);
      REG_ENERGY_THR:   prdata = 32'(energy_threshold);
      default:          prdata = '0;
    endcase
  end

  // sequencer: walks clear, scan, merge and readout steps
  chtm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  // memories, arithmetic and the result register
  chtm_datapath #(
    .NUM_CELLS(NUM_CELLS), .HITS_PER_CELL(HITS_PER_CELL)
  ) u_datapath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .cell_req(cell_req), .deposit_time(deposit_time),
    .deposit_energy(deposit_energy), .local_z(local_z),
    .merge_window(merge_window), .hit_limit(hit_limit),
    .energy_threshold(energy_threshold),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .hit_cell(hit_cell), .hit_time(hit_time), .hit_energy(hit_energy),
    .hit_z(hit_z), .last(last)
  );

endmodule
`default_nettype wire
